// File: rtl/assert_macros.svh
// Assertion macros shared by the hasher RTL.
// Included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: rtl/md5_pkg.sv
// Shared types and constants for the MD5 stream hasher.
// No dependencies.
package md5_pkg;
	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [31:0] ROT_PACKED [4] = '{32'h16110c07, 32'h140e0905,
		32'h17100b04, 32'h150f0a06};
	localparam logic [31:0] ROUND_KEYS [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

	// Byte sources for the datapath byte writer.
	typedef enum logic [1:0] {
		SRC_DATA = 2'd0,
		SRC_PAD = 2'd1,
		SRC_ZERO = 2'd2,
		SRC_LEN = 2'd3
	} byte_src_t;

	typedef struct packed {
		logic put_byte;
		byte_src_t src;
		logic add_len;
		logic start_round;
		logic round_en;
		logic fold;
		logic reinit;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic last_round;
	} dp_status_t;
endpackage

// File: rtl/md5_datapath.sv
// Datapath: block buffer, bit counter, one MD5 round per cycle, chain words.
// Uses md5_pkg.
module md5_datapath (
	input logic clk,
	input logic arst_n,
	input md5_pkg::dp_cmd_t cmd,
	input logic [7:0] data_byte,
	output md5_pkg::dp_status_t status,
	output logic [31:0] chain0,
	output logic [31:0] chain1,
	output logic [31:0] chain2,
	output logic [31:0] chain3
);
	import md5_pkg::*;

	logic [31:0] block_q [16];
	logic [31:0] chain_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [63:0] bits_q;
	logic [5:0] fill_q;
	logic [5:0] round_q;
	logic [7:0] wbyte;
	logic [1:0] quarter;
	logic [3:0] g;
	logic [31:0] f, t, r;
	logic [4:0] sh;
	logic [3:0] wsel;

	always_comb begin
		unique case (cmd.src)
			SRC_DATA: wbyte = data_byte;
			SRC_PAD: wbyte = PAD_BYTE;
			SRC_ZERO: wbyte = 8'h00;
			SRC_LEN: wbyte = bits_q[{fill_q[2:0], 3'b000} +: 8];
			default: wbyte = 8'h00;
		endcase
	end

	assign quarter = round_q[5:4];
	always_comb begin
		unique case (quarter)
			2'd0: begin
				f = d_q ^ (b_q & (c_q ^ d_q));
				g = round_q[3:0];
			end
			2'd1: begin
				f = c_q ^ (d_q & (b_q ^ c_q));
				g = 4'(5 * round_q[3:0] + 1);
			end
			2'd2: begin
				f = b_q ^ c_q ^ d_q;
				g = 4'(3 * round_q[3:0] + 5);
			end
			default: begin
				f = c_q ^ (b_q | ~d_q);
				g = 4'(7 * round_q[3:0]);
			end
		endcase
		t = a_q + f + block_q[g] + ROUND_KEYS[round_q];
		sh = ROT_PACKED[quarter][{round_q[1:0], 3'b000} +: 5];
		r = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
	end

	assign wsel = fill_q[5:2];

	always_ff @(posedge clk) begin
		if (cmd.put_byte) begin
			block_q[wsel][{fill_q[1:0], 3'b000} +: 8] <= wbyte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '{IV0, IV1, IV2, IV3};
			bits_q <= '0;
			fill_q <= '0;
			round_q <= '0;
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
			d_q <= '0;
		end else begin
			if (cmd.put_byte) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.add_len) begin
				bits_q <= bits_q + 64'd8;
			end
			if (cmd.start_round) begin
				a_q <= chain_q[0];
				b_q <= chain_q[1];
				c_q <= chain_q[2];
				d_q <= chain_q[3];
				round_q <= '0;
			end else if (cmd.round_en) begin
				a_q <= d_q;
				d_q <= c_q;
				c_q <= b_q;
				b_q <= b_q + r;
				round_q <= round_q + 6'd1;
			end
			if (cmd.reinit) begin
				chain_q <= '{IV0, IV1, IV2, IV3};
				bits_q <= '0;
				fill_q <= '0;
			end else if (cmd.fold) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
			end
		end
	end

	assign status.fill = fill_q;
	assign status.last_round = (round_q == 6'd63);
	assign chain0 = chain_q[0];
	assign chain1 = chain_q[1];
	assign chain2 = chain_q[2];
	assign chain3 = chain_q[3];
endmodule

// File: rtl/md5_ctrl.sv
// Controller: sequences byte writes, padding, compression and digest output.
// Uses md5_pkg.
module md5_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic in_action,
	input logic out_stall,
	output logic out_valid,
	output logic [1:0] out_index,
	output md5_pkg::dp_cmd_t cmd,
	input md5_pkg::dp_status_t status
);
	import md5_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_LOAD = 7'b0000010,
		ST_ROUND = 7'b0000100,
		ST_FOLD = 7'b0001000,
		ST_PAD = 7'b0010000,
		ST_LEN = 7'b0100000,
		ST_OUT = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic final_q, final_d;
	logic [1:0] idx_q, idx_d;
	logic take;

	assign in_stall = (state_q != ST_IDLE);
	assign take = in_valid && (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_index = idx_q;

	always_comb begin
		state_d = state_q;
		final_d = final_q;
		idx_d = idx_q;
		cmd = '0;
		cmd.src = SRC_DATA;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					cmd.put_byte = 1'b1;
					if (in_action) begin
						cmd.src = SRC_PAD;
						final_d = 1'b1;
						state_d = (status.fill == 6'd63) ? ST_LOAD :
							(status.fill == 6'd55) ? ST_LEN : ST_PAD;
					end else begin
						cmd.add_len = 1'b1;
						final_d = 1'b0;
						if (status.fill == 6'd63) begin
							state_d = ST_LOAD;
						end
					end
				end
			end
			ST_LOAD: begin
				cmd.start_round = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				if (status.last_round) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				if (!final_q) begin
					state_d = ST_IDLE;
				end else if (status.fill == 6'd0 && idx_q == 2'd3) begin
					// Length already written: the digest is ready.
					idx_d = 2'd0;
					state_d = ST_OUT;
				end else begin
					state_d = (status.fill == 6'd56) ? ST_LEN : ST_PAD;
					idx_d = 2'd0;
				end
			end
			ST_PAD: begin
				cmd.put_byte = 1'b1;
				cmd.src = SRC_ZERO;
				if (status.fill == 6'd63) begin
					state_d = ST_LOAD;
				end else if (status.fill == 6'd55) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				cmd.put_byte = 1'b1;
				cmd.src = SRC_LEN;
				if (status.fill == 6'd63) begin
					idx_d = 2'd3;
					state_d = ST_LOAD;
				end
			end
			ST_OUT: begin
				if (!out_stall) begin
					idx_d = idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						cmd.reinit = 1'b1;
						final_d = 1'b0;
						idx_d = 2'd0;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			final_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			final_q <= final_d;
			idx_q <= idx_d;
		end
	end
endmodule

// File: rtl/md5_stream_hasher.sv
// MD5 stream hasher, one message byte or one finalize per input item.
// Channels: input (valid, stall, action, data_byte) and output
// (out_valid, out_stall, digest_word, word_index, last_word).
// An absorb item is taken while idle; the byte that fills a 64-byte block
// starts the compression, which runs a load step, the MD5 rounds on one
// round unit and a fold step, and that item holds the input off until the fold.
// The input is stalled while a compression runs, so bytes wait until it ends.
// A finalize item writes the padding, one byte per cycle between compressions
// and over up to two blocks, runs one or two compressions, then shows four digest
// words, lowest first, one per cycle while out_stall is low; last_word marks
// the fourth.
// The input stays stalled until the fourth word is taken, after which the
// chain words, bit count and fill return to the MD5 initial values.
// A stalled output word holds. Reset (arst_n low) clears the controller and
// counters, sets chain words to the IVs and leaves the block buffer unwritten.
// Files: md5_pkg, md5_ctrl, md5_datapath, assert_macros.svh.
module md5_stream_hasher (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic stall,
	input logic action,
	input logic [7:0] data_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] digest_word,
	output logic [1:0] word_index,
	output logic last_word
);
	import md5_pkg::*;
	`include "assert_macros.svh"

	dp_cmd_t cmd;
	dp_status_t status;
	logic [31:0] c0, c1, c2, c3;

	md5_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(valid), .in_stall(stall),
		.in_action(action), .out_stall(out_stall), .out_valid(out_valid),
		.out_index(word_index), .cmd(cmd), .status(status)
	);

	md5_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .data_byte(data_byte),
		.status(status), .chain0(c0), .chain1(c1), .chain2(c2), .chain3(c3)
	);

	always_comb begin
		unique case (word_index)
			2'd0: digest_word = c0;
			2'd1: digest_word = c1;
			2'd2: digest_word = c2;
			default: digest_word = c3;
		endcase
	end
	assign last_word = (word_index == 2'd3);

	`ASSERT_IMPL(a_no_accept_while_out, clk, arst_n, out_valid, stall, "input open during output")
	`ASSERT_NEXT(a_reinit_fill, clk, arst_n, out_valid && !out_stall && last_word, status.fill == 6'd0 && !out_valid, "no reinit after digest")
	`ASSERT_IMPL(a_one_cmd, clk, arst_n, 1'b1, !(cmd.put_byte && cmd.round_en), "byte write during round")
endmodule

// File: tb/tb_md5_stream_hasher.sv
// Self-checking testbench for md5_stream_hasher: byte and finalize items go in,
// digests are predicted by a behavioral MD5 engine and compared word by word.
// Depends on md5_pkg for the initial values, round keys and rotate amounts.
module tb_md5_stream_hasher;
	import md5_pkg::*;

	localparam logic ACT_ABSORB = 1'b0;
	localparam logic ACT_FINAL = 1'b1;
	localparam int IDLE_LIMIT = 4000;

	typedef struct packed {
		logic action;
		logic [7:0] data_byte;
	} hash_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic [1:0] index;
		logic last;
	} digest_out_t;

	logic clk = 1'b0;
	logic arst_n;
	logic valid;
	logic stall;
	logic action;
	logic [7:0] data_byte;
	logic out_valid;
	logic out_stall;
	logic [31:0] digest_word;
	logic [1:0] word_index;
	logic last_word;

	md5_stream_hasher dut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall), .action(action),
		.data_byte(data_byte), .out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	hash_item_t pending_items[$];
	digest_out_t expected_words[$];

	// Predictor state.
	logic [31:0] chain[4];
	logic [63:0] msg_bits;
	logic [31:0] block_buf[16];
	logic [5:0] fill;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_recv;
	bit gate_send;
	int mismatches;
	int idle_cycles;
	bit timed_out;

	function automatic logic [31:0] rotl(logic [31:0] v, int s);
		return (s == 0) ? v : ((v << s) | (v >> (32 - s)));
	endfunction

	task automatic md5_init();
		chain[0] = IV0;
		chain[1] = IV1;
		chain[2] = IV2;
		chain[3] = IV3;
		msg_bits = '0;
		fill = '0;
	endtask

	task automatic md5_compress();
		logic [31:0] a, b, c, d, f, t;
		int g, q;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		for (int i = 0; i < 64; i++) begin
			q = i / 16;
			case (q)
				0: begin f = d ^ (b & (c ^ d)); g = i; end
				1: begin f = c ^ (d & (b ^ c)); g = (5 * i + 1) % 16; end
				2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
				default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
			endcase
			t = a + f + block_buf[g] + ROUND_KEYS[i];
			t = rotl(t, (ROT_PACKED[q] >> ((i % 4) * 8)) & 32'hff);
			a = d;
			d = c;
			c = b;
			b = b + t;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
	endtask

	task automatic md5_put(logic [7:0] v);
		block_buf[fill[5:2]][fill[1:0] * 8 +: 8] = v;
		fill = fill + 6'd1;
		if (fill == 0)
			md5_compress();
	endtask

	task automatic predict_item(hash_item_t it);
		logic [63:0] len;
		if (it.action == ACT_ABSORB) begin
			md5_put(it.data_byte);
			msg_bits += 64'd8;
		end else begin
			len = msg_bits;
			md5_put(PAD_BYTE);
			while (fill != 6'd56)
				md5_put(8'h00);
			for (int k = 0; k < 8; k++)
				md5_put(len[8 * k +: 8]);
			for (int k = 0; k < 4; k++)
				expected_words.push_back('{chain[k], 2'(k), k == 3});
			md5_init();
		end
	endtask

	task automatic add_message(int n);
		for (int i = 0; i < n; i++)
			pending_items.push_back('{ACT_ABSORB, 8'($urandom)});
		pending_items.push_back('{ACT_FINAL, 8'($urandom)});
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || valid || expected_words.size() != 0)
			@(posedge clk);
	endtask

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Driver: presents queued items; a payload only changes once accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
			action <= 1'b0;
			data_byte <= '0;
		end else if (!valid || !stall) begin
			if (pending_items.size() != 0 && !gate_send
					&& $urandom_range(99) >= send_idle_pct) begin
				hash_item_t it;
				it = pending_items.pop_front();
				predict_item(it);
				valid <= 1'b1;
				action <= it.action;
				data_byte <= it.data_byte;
			end else begin
				valid <= 1'b0;
			end
		end
	end

	// Receiver stall, with an optional long hold-off counted here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else if (hold_recv > 0) begin
			out_stall <= 1'b1;
			hold_recv <= hold_recv - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Monitor and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected digest word %h idx %0d", digest_word, word_index);
				end else begin
					digest_out_t e;
					e = expected_words.pop_front();
					if (e.word !== digest_word || e.index !== word_index
							|| e.last !== last_word) begin
						mismatches++;
						if (mismatches <= 10)
							$display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
								e.word, e.index, e.last, digest_word, word_index, last_word);
					end
				end
			end
			if ((valid && !stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT)
				timed_out <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (timed_out) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int count;
		md5_init();
		for (int i = 0; i < 16; i++)
			block_buf[i] = '0;
		send_idle_pct = 31;
		recv_idle_pct = 58;
		hold_recv = 0;
		gate_send = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty message, extreme bytes, a data byte on finalize,
		// and lengths around the padding boundary.
		pending_items.push_back('{ACT_FINAL, 8'hff});
		pending_items.push_back('{ACT_ABSORB, 8'h00});
		pending_items.push_back('{ACT_ABSORB, 8'hff});
		pending_items.push_back('{ACT_FINAL, 8'h00});
		add_message(55);
		add_message(56);
		add_message(64);
		wait_drained();

		// Phase one: sender idles less than receiver, plus a long hold-off.
		send_idle_pct = 31;
		recv_idle_pct = 58;
		hold_recv = 300;
		count = 0;
		while (count < 80) begin
			int n;
			n = $urandom_range(3) == 0 ? $urandom_range(120) : $urandom_range(20);
			add_message(n);
			count += n + 1;
		end
		wait_drained();

		// The sender is gated while these items are queued, then idles more than the receiver.
		gate_send = 1'b1;
		send_idle_pct = 58;
		recv_idle_pct = 31;
		count = 0;
		while (count < 80) begin
			int n;
			n = $urandom_range(40);
			add_message(n);
			count += n + 1;
		end
		gate_send = 1'b0;
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		count = 0;
		while (count < 80) begin
			int n;
			n = $urandom_range(70);
			add_message(n);
			count += n + 1;
		end
		wait_drained();
		repeat (200) @(posedge clk);

		if (mismatches == 0 && expected_words.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// File: md5_stream_hasher.f
+incdir+rtl
rtl/md5_pkg.sv
rtl/md5_datapath.sv
rtl/md5_ctrl.sv
rtl/md5_stream_hasher.sv
tb/tb_md5_stream_hasher.sv
